// ----- sv/rsdz_pkg.sv -----
// Package for the radial stick dead zone block: widths and constants, among them
// the root and divider bit widths that set how deep each of those pipelines is.
`default_nettype none
package rsdz_pkg;
  localparam int unsigned FULL_SCALE = 32767;
  localparam logic [14:0] RESET_LEFT_DZ = 15'd7849;
  localparam logic [14:0] RESET_RIGHT_DZ = 15'd8689;
  localparam logic CFG_LEFT = 1'b0;
  localparam logic CFG_RIGHT = 1'b1;
  // Restoring divider: 31-bit dividend, 16-bit divisor, 31-bit quotient.
  localparam int unsigned DIV_N = 31;
  localparam int unsigned SQRT_BITS = 16;
  // Side data beside the root: |x|, |y|, two signs and the dead zone.
  localparam int unsigned SQ_SIDE_W = 16 + 16 + 2 + 15;
  // Side data beside a divider: magnitude, |x|, |y|, signs, dead, full.
  localparam int unsigned DIV_SIDE_W = 16 + 16 + 16 + 2 + 2;
endpackage
`default_nettype wire

// ----- sv/radial_stick_dead_zone.sv -----
// Radial dead zone for one thumbstick sample pair, scaled to Q1.15.
// Input channel: stick_x, stick_y, command with in_valid / in_stall.
// Output channel: out_x, out_y, in_dead_zone with out_valid / out_stall.
// A transfer happens where valid is high and stall low on that channel.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 left dead zone,
// index 1 right dead zone. Write only while idle.
// Throughput: one sample per cycle while the output is not stalled.
// Pipeline registers in order: squares, square root stages, scale divide
// stages, product, component divide stages, output.
// The latency follows from the bit-serial root and the restoring dividers,
// one bit per stage.
// Stall: the whole pipeline holds while the output register is full and
// stalled; in_stall is then high, and nothing is lost or repeated.
// Reset: synchronous, clears all valid bits and loads the default dead
// zones (left 7849, right 8689).
`default_nettype none
module radial_stick_dead_zone import rsdz_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] stick_x,
  input  wire logic signed [15:0] stick_y,
  input  wire logic               command,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic                    in_dead_zone,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data
);
  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic        en;

  // Advance everything unless a finished result waits and is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= RESET_LEFT_DZ;
      right_dz <= RESET_RIGHT_DZ;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEFT) left_dz <= cfg_data;
      if (cfg_index == CFG_RIGHT) right_dz <= cfg_data;
    end
  end

  // Stage 1: component magnitudes, the sum of their squares, signs and dead zone.
  logic        s1_valid;
  logic [31:0] s1_sq;
  logic [15:0] s1_ax, s1_ay;
  logic        s1_nx, s1_ny;
  logic [14:0] s1_dz;
  logic [15:0] ax_c, ay_c;
  assign ax_c = stick_x[15] ? 16'(-stick_x) : 16'(stick_x);
  assign ay_c = stick_y[15] ? 16'(-stick_y) : 16'(stick_y);

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_sq <= 32'(ax_c * ax_c) + 32'(ay_c * ay_c);
      s1_ax <= ax_c;
      s1_ay <= ay_c;
      s1_nx <= stick_x[15];
      s1_ny <= stick_y[15];
      s1_dz <= command ? right_dz : left_dz;
    end
  end

  // Square root; side data holds |x|, |y|, signs and dead zone.
  logic                 s2_valid;
  logic [15:0]          s2_mag;
  logic [SQ_SIDE_W-1:0] s2_side;
  rsdz_isqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (s1_valid),
    .in_value (s1_sq),
    .in_side  ({s1_ax, s1_ay, s1_nx, s1_ny, s1_dz}),
    .out_valid(s2_valid),
    .out_root (s2_mag),
    .out_side (s2_side)
  );

  logic [14:0] s2_dz;
  logic        s2_dead;
  logic        s2_full;
  logic [30:0] s2_num;
  logic [15:0] s2_den;
  assign s2_dz   = s2_side[14:0];
  assign s2_dead = (s2_mag == 16'd0) || (s2_mag < {1'b0, s2_dz});
  assign s2_full = ({1'b0, s2_dz} >= 16'(FULL_SCALE));
  // mag - dz fits 16 bits when not dead; times 32767 fits 31 bits.
  assign s2_num  = s2_dead ? 31'd0
                 : 31'((s2_mag - {1'b0, s2_dz}) * 16'(FULL_SCALE));
  assign s2_den  = s2_full ? 16'd1 : 16'(16'(FULL_SCALE) - {1'b0, s2_dz});

  logic                  s3_valid;
  logic [30:0]           s3_quot;
  logic [DIV_SIDE_W-1:0] s3_side;
  rsdz_div u_scale_div (
    .clk, .rst, .en,
    .in_valid (s2_valid),
    .in_num   (s2_num),
    .in_den   (s2_den),
    .in_side  ({s2_mag, s2_side[48:17], s2_side[16:15], s2_dead, s2_full}),
    .out_valid(s3_valid),
    .out_quot (s3_quot),
    .out_side (s3_side)
  );

  // Saturate the scale, then form |c| * scale for both components.
  logic [15:0] s3_mag, s3_ax, s3_ay;
  logic        s3_dead, s3_full;
  logic [1:0]  s3_sg;
  logic [14:0] s3_scale;
  assign {s3_mag, s3_ax, s3_ay, s3_sg, s3_dead, s3_full} = s3_side;
  assign s3_scale = (s3_full || s3_quot > 31'(FULL_SCALE))
                  ? 15'(FULL_SCALE) : s3_quot[14:0];

  logic        s4_valid;
  logic [30:0] s4_px, s4_py;
  logic [15:0] s4_mag;
  logic [1:0]  s4_sg;
  logic        s4_dead;
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
    if (en) begin
      s4_px   <= 31'(s3_ax * s3_scale);
      s4_py   <= 31'(s3_ay * s3_scale);
      s4_mag  <= s3_dead ? 16'd1 : s3_mag;
      s4_sg   <= s3_sg;
      s4_dead <= s3_dead;
    end
  end

  // Signs and the dead flag ride in the low side bits; pad the rest.
  logic                  dx_valid, dy_valid;
  logic [30:0]           qx, qy;
  logic [DIV_SIDE_W-1:0] dx_side;
  logic [DIV_SIDE_W-1:0] dy_side;
  rsdz_div u_x_div (
    .clk, .rst, .en,
    .in_valid (s4_valid),
    .in_num   (s4_px),
    .in_den   (s4_mag),
    .in_side  ({(DIV_SIDE_W-3)'(0), s4_sg, s4_dead}),
    .out_valid(dx_valid),
    .out_quot (qx),
    .out_side (dx_side)
  );
  rsdz_div u_y_div (
    .clk, .rst, .en,
    .in_valid (s4_valid),
    .in_num   (s4_py),
    .in_den   (s4_mag),
    .in_side  ({(DIV_SIDE_W-3)'(0), s4_sg, s4_dead}),
    .out_valid(dy_valid),
    .out_quot (qy),
    .out_side (dy_side)
  );

  // Output register: apply signs, force zero inside the dead zone.
  logic [15:0] rx, ry;
  assign rx = dx_side[2] ? 16'(-qx[15:0]) : qx[15:0];
  assign ry = dx_side[1] ? 16'(-qy[15:0]) : qy[15:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dx_valid;
    if (en) begin
      out_x        <= dx_side[0] ? 16'sd0 : $signed(rx);
      out_y        <= dx_side[0] ? 16'sd0 : $signed(ry);
      in_dead_zone <= dx_side[0];
    end
  end

  // The two component dividers run in lock step.
  assert property (@(posedge clk) disable iff (rst)
    (dx_valid == dy_valid) && (!dx_valid || (dx_side == dy_side)))
    else $error("component dividers out of step");
  // A stalled result holds its place.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    else $error("stalled result changed");
  // Dead zone results are zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_dead_zone) |-> (out_x == 16'sd0 && out_y == 16'sd0))
    else $error("dead zone result not zero");
endmodule
`default_nettype wire

// ----- sv/rsdz_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on rsdz_pkg. Side data travels alongside as an opaque vector.
`default_nettype none
module rsdz_isqrt import rsdz_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [31:0]          in_value,
  input  wire logic [SQ_SIDE_W-1:0] in_side,
  output logic                      out_valid,
  output logic [15:0]               out_root,
  output logic [SQ_SIDE_W-1:0]      out_side
);
  logic [SQRT_BITS:0]   vld;
  logic [33:0]          rem  [SQRT_BITS+1];
  logic [15:0]          root [SQRT_BITS+1];
  logic [31:0]          val  [SQRT_BITS+1];
  logic [SQ_SIDE_W-1:0] side [SQRT_BITS+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    root[0] = '0;
    val[0]  = in_value;
    side[0] = in_side;
  end

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_stage
    logic [33:0] trial;
    logic [33:0] shifted;
    always_comb begin
      shifted = {rem[i][31:0], val[i][31:30]};
      trial   = shifted - {16'd0, root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        val[i+1]  <= {val[i][29:0], 2'b00};
        side[i+1] <= side[i];
        if (!trial[33]) begin
          rem[i+1]  <= trial;
          root[i+1] <= {root[i][14:0], 1'b1};
        end else begin
          rem[i+1]  <= shifted;
          root[i+1] <= {root[i][14:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[SQRT_BITS];
  assign out_root  = root[SQRT_BITS];
  assign out_side  = side[SQRT_BITS];
endmodule
`default_nettype wire

// ----- sv/rsdz_div.sv -----
// Pipelined restoring divider of a 31-bit dividend by a 16-bit divisor.
// Depends on rsdz_pkg. Side data travels alongside as an opaque vector.
`default_nettype none
module rsdz_div import rsdz_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [DIV_N-1:0]      in_num,
  input  wire logic [15:0]           in_den,
  input  wire logic [DIV_SIDE_W-1:0] in_side,
  output logic                       out_valid,
  output logic [DIV_N-1:0]           out_quot,
  output logic [DIV_SIDE_W-1:0]      out_side
);
  logic [DIV_N:0]          vld;
  logic [16:0]             rem  [DIV_N+1];
  logic [DIV_N-1:0]        num  [DIV_N+1];
  logic [15:0]             den  [DIV_N+1];
  logic [DIV_SIDE_W-1:0]   side [DIV_N+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    num[0]  = in_num;
    den[0]  = in_den;
    side[0] = in_side;
  end

  for (genvar i = 0; i < DIV_N; i++) begin : g_stage
    logic [16:0] shifted;
    logic [17:0] diff;
    always_comb begin
      shifted = {rem[i][15:0], num[i][DIV_N-1]};
      diff    = {1'b0, shifted} - {2'b00, den[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
        if (!diff[17]) begin
          rem[i+1] <= diff[16:0];
          num[i+1] <= {num[i][DIV_N-2:0], 1'b1};
        end else begin
          rem[i+1] <= shifted;
          num[i+1] <= {num[i][DIV_N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[DIV_N];
  assign out_quot  = num[DIV_N];
  assign out_side  = side[DIV_N];
endmodule
`default_nettype wire

// ----- tb/radial_stick_dead_zone_tb.sv -----
// Self-checking bench for the radial stick dead zone block: directed corners,
// dead zone settings and random stick traffic under random idling and stalls.
// Depends on rsdz_pkg and the radial_stick_dead_zone RTL with rsdz_isqrt and rsdz_div.
`default_nettype none
module radial_stick_dead_zone_tb;
  import rsdz_pkg::*;

  localparam int PIPE_LATENCY = 81;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               in_dz;
  } stick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] stick_x = '0;
  logic signed [15:0] stick_y = '0;
  logic command = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic in_dead_zone;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LEFT;
  logic [14:0] cfg_data = '0;

  // Shadow copy of the dead zone registers
  logic [14:0] left_dz_shadow;
  logic [14:0] right_dz_shadow;

  stick_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int dz_hits = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;

  radial_stick_dead_zone u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .stick_x(stick_x), .stick_y(stick_y), .command(command),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .in_dead_zone(in_dead_zone),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor square root by bit-by-bit search
  function automatic logic [31:0] root_floor(input logic [63:0] v);
    logic [31:0] r;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      logic [31:0] t;
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] scale_axis(input logic signed [15:0] c,
                                                    input logic [31:0] scale,
                                                    input logic [31:0] mag);
    logic [63:0] a;
    logic [63:0] q;
    a = (c < 0) ? 64'(-$signed(32'(c))) : 64'(c);
    q = (a * scale) / mag;
    return (c < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic stick_result_t predict_dead_zone(input logic signed [15:0] x,
                                                      input logic signed [15:0] y,
                                                      input logic sel);
    stick_result_t res;
    logic [31:0] dz;
    logic [31:0] mag;
    logic [63:0] s;
    logic [31:0] scale;
    dz = (sel == CFG_RIGHT) ? right_dz_shadow : left_dz_shadow;
    mag = root_floor(64'($signed(32'(x)) * $signed(32'(x))) +
                     64'($signed(32'(y)) * $signed(32'(y))));
    res = '0;
    if (mag == 0 || mag < dz) begin
      res.in_dz = 1'b1;
      return res;
    end
    if (dz >= FULL_SCALE) scale = FULL_SCALE;
    else begin
      s = (64'(mag - dz) * FULL_SCALE) / 64'(FULL_SCALE - dz);
      scale = (s > FULL_SCALE) ? FULL_SCALE : s[31:0];
    end
    res.sx = scale_axis(x, scale, mag);
    res.sy = scale_axis(y, scale, mag);
    return res;
  endfunction

  // Receiver stall pattern: phases of random stalls and phases of none
  always @(posedge clk) begin
    if (rst || !stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(0, 199) < 60) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    stick_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d dz=%0b", out_x, out_y, in_dead_zone);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_x !== exp_r.sx) begin
          $error("out_x expected %0d actual %0d", exp_r.sx, out_x);
          errors++;
        end
        if (out_y !== exp_r.sy) begin
          $error("out_y expected %0d actual %0d", exp_r.sy, out_y);
          errors++;
        end
        if (in_dead_zone !== exp_r.in_dz) begin
          $error("in_dead_zone expected %0b actual %0b", exp_r.in_dz, in_dead_zone);
          errors++;
        end
        if (exp_r.in_dz) dz_hits++;
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_q.size());
      $display("radial_stick_dead_zone regression: fail");
      $finish;
    end
  end

  // Send one sample; hold it until the transfer, predict on acceptance
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic sel);
    stick_x <= x;
    stick_y <= y;
    command <= sel;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_dead_zone(x, y, sel));
    items_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the pipeline drain fully before touching the registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic sel, input logic [14:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_RIGHT) right_dz_shadow = value;
    else left_dz_shadow = value;
  endtask

  task automatic test_corners();
    logic signed [15:0] axis_vals[6];
    axis_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5A82};
    // Zero magnitude, extremes, corners, and both selects
    foreach (axis_vals[i]) begin
      send_sample(axis_vals[i], axis_vals[(i + 1) % 6], i[0]);
      send_sample(axis_vals[i], axis_vals[i], ~i[0]);
    end
    send_sample(16'sd7849, 16'sd0, CFG_LEFT);
    send_sample(16'sd7848, 16'sd0, CFG_LEFT);
    send_sample(16'sd0, -16'sd8689, CFG_RIGHT);
    send_sample(16'sd0, -16'sd8688, CFG_RIGHT);
    drop_valid();
  endtask

  task automatic test_dead_zone_extremes();
    // Extreme dead zones; with a zero one, magnitude one is live, origin stays dead
    wait_drained();
    write_dead_zone(CFG_LEFT, 15'd0);
    write_dead_zone(CFG_RIGHT, 15'd32767);
    send_sample(16'sd0, 16'sd0, CFG_LEFT);
    send_sample(16'sd1, 16'sd0, CFG_LEFT);
    send_sample(-16'sd1, -16'sd1, CFG_LEFT);
    send_sample(16'sh7FFF, 16'sd0, CFG_RIGHT);
    send_sample(16'sh8000, 16'sh8000, CFG_RIGHT);
    send_sample(16'sd20000, 16'sd20000, CFG_RIGHT);
    send_sample(16'sd100, 16'sd0, CFG_RIGHT);
    drop_valid();
    wait_drained();
    write_dead_zone(CFG_LEFT, 15'd32766);
    write_dead_zone(CFG_RIGHT, 15'd1);
    send_sample(16'sh7FFF, 16'sd0, CFG_LEFT);
    send_sample(16'sd32766, 16'sd5, CFG_LEFT);
    send_sample(16'sd1, 16'sd0, CFG_RIGHT);
    drop_valid();
  endtask

  function automatic logic signed [15:0] random_axis();
    case ($urandom_range(0, 3))
      0: return $signed(16'($urandom()));
      1: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      2: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 30))
                                     : 16'sh8000 + 16'($urandom_range(0, 30));
      default: return $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
    endcase
  endfunction

  // Bursts of samples, most of them followed by a random gap
  task automatic test_random_traffic(input int count);
    int burst;
    for (int n = 0; n < count;) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < count; b++, n++)
        send_sample(random_axis(), random_axis(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    drop_valid();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_dead_zone(CFG_LEFT, 15'($urandom_range(0, 32767)));
      write_dead_zone(CFG_RIGHT, 15'($urandom_range(0, 16000)));
      stall_enable = (phase != 2);
      test_random_traffic(200);
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    left_dz_shadow = RESET_LEFT_DZ;
    right_dz_shadow = RESET_RIGHT_DZ;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_dead_zone_extremes();
    wait_drained();
    write_dead_zone(CFG_LEFT, RESET_LEFT_DZ);
    write_dead_zone(CFG_RIGHT, RESET_RIGHT_DZ);
    test_random_traffic(200);
    test_random_settings();
    wait_drained();
    $display("covered %0d samples, %0d results, %0d inside the dead zone",
             items_sent, results_seen, dz_hits);
    if (errors == 0) $display("radial_stick_dead_zone regression: pass");
    else $display("radial_stick_dead_zone regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
